// ===== rtl/core/escaped_frame_receiver_defines.svh =====
// Assertion macros used by the frame receiver RTL.
`ifndef ESCAPED_FRAME_RECEIVER_DEFINES_SVH
`define ESCAPED_FRAME_RECEIVER_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define EFR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define EFR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/efr_pkg.sv =====
// Types and byte codes of the escaped frame receiver.
package efr_pkg;

  localparam logic [7:0] SYM_STX = 8'h02;
  localparam logic [7:0] SYM_ETX = 8'h03;
  localparam logic [7:0] SYM_ENQ = 8'h05;
  localparam logic [7:0] SYM_DC2 = 8'h12;
  localparam logic [7:0] SYM_DC3 = 8'h13;
  localparam logic [7:0] SYM_NAK = 8'h15;
  localparam logic [7:0] NAK_LEN = 8'h01;
  localparam logic [7:0] NAK_SUM = 8'hE8;
  localparam logic [8:0] COUNT_MAX = 9'd511;

  localparam logic KIND_MSG    = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef struct packed {
    logic       in_frame;
    logic       escape_pending;
    logic       header_seen;
    logic       held_valid;
    logic [7:0] held_value;
    logic [7:0] length_value;
    logic [7:0] running_sum;
    logic [8:0] message_count;
    logic [7:0] first_message;
  } efr_state_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] value;
    logic       checksum_ok;
    logic       length_ok;
    logic       nak_reply;
  } efr_item_t;

  typedef struct packed {
    efr_state_t st;
    logic       emit;
    logic [7:0] value;
  } efr_deliver_t;

endpackage

// ===== rtl/core/escaped_frame_receiver.sv =====
// Escaped STX/ETX frame receiver: destuffing, checksum and length check.
// A result is written into the result queue by the input transfer that causes it.
// Throughput: one raw byte per cycle while rx_stall is low; a byte that yields
//   two results is absorbed by the four-entry result queue.
// Input stalls only when the queue holds more than two results.
// Reset (rst, synchronous): frame state cleared, result queue emptied.
module escaped_frame_receiver
  import efr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  // raw byte channel
  input  logic       rx_valid,
  output logic       rx_stall,
  input  logic [7:0] rx_byte,
  // result channel
  output logic       res_valid,
  input  logic       res_stall,
  output logic       item_kind,
  output logic [7:0] msg_byte,
  output logic       checksum_ok,
  output logic       length_ok,
  output logic       nak_reply,
  output logic       frame_last
);

  `include "escaped_frame_receiver_defines.svh"

  localparam efr_state_t IDLE_STATE = '0;

  // Push one destuffed byte into the frame state. The first byte is the
  // length; after that each new byte releases the previously held one.
  function automatic efr_deliver_t deliver(efr_state_t s, logic [7:0] d);
    efr_deliver_t r;
    r.st    = s;
    r.emit  = 1'b0;
    r.value = s.held_value;
    if (!s.header_seen) begin
      r.st.header_seen  = 1'b1;
      r.st.length_value = d;
      r.st.running_sum  = s.running_sum + d;
    end else begin
      if (s.held_valid) begin
        r.emit           = 1'b1;
        r.st.running_sum = s.running_sum + s.held_value;
        if (s.message_count == '0) begin
          r.st.first_message = s.held_value;
        end
        if (s.message_count != COUNT_MAX) begin
          r.st.message_count = s.message_count + 9'd1;
        end
      end
      r.st.held_value = d;
      r.st.held_valid = 1'b1;
    end
    return r;
  endfunction

  function automatic efr_item_t msg_item(logic [7:0] v);
    efr_item_t it;
    it             = '0;
    it.kind        = KIND_MSG;
    it.value       = v;
    return it;
  endfunction

  // frame state
  efr_state_t st, st_next;

  // result queue
  efr_item_t  fifo [4];
  logic [1:0] wr_ptr, rd_ptr;
  logic [2:0] count, count_next;

  logic rx_xfer, res_xfer;

  // byte decode
  logic         d1_valid, d2_valid;
  logic [7:0]   d1_byte, d2_byte;
  logic         esc_next, open_frame, close_frame;
  efr_deliver_t r1, r2;
  efr_state_t   s1, s2;
  logic         e1, e2, hv;
  efr_item_t    status, it0, it1;
  logic [1:0]   n_items;

  assign rx_stall  = (count > 3'd2);
  assign rx_xfer   = rx_valid && !rx_stall;
  assign res_valid = (count != '0);
  assign res_xfer  = res_valid && !res_stall;

  // Work out which destuffed bytes this raw byte produces (at most two).
  always_comb begin
    d1_valid    = 1'b0;
    d2_valid    = 1'b0;
    d1_byte     = SYM_ENQ;
    d2_byte     = rx_byte;
    esc_next    = st.escape_pending;
    open_frame  = 1'b0;
    close_frame = 1'b0;
    if (rx_byte == SYM_STX) begin
      open_frame = 1'b1;
    end else if (st.in_frame) begin
      if (rx_byte == SYM_ETX) begin
        // a dangling ENQ before ETX is plain data
        close_frame = 1'b1;
        d1_valid    = st.escape_pending;
        esc_next    = 1'b0;
      end else if (st.escape_pending) begin
        esc_next = 1'b0;
        d1_valid = 1'b1;
        case (rx_byte)
          SYM_DC2: d1_byte = SYM_STX;
          SYM_DC3: d1_byte = SYM_ETX;
          SYM_NAK: d1_byte = SYM_ENQ;
          SYM_ENQ: esc_next = 1'b1;  // first ENQ passes, second opens escape
          default: d2_valid = 1'b1;  // unknown pair: both bytes pass
        endcase
      end else if (rx_byte == SYM_ENQ) begin
        esc_next = 1'b1;
      end else begin
        d1_valid = 1'b1;
        d1_byte  = rx_byte;
      end
    end
  end

  assign r1 = deliver(st, d1_byte);
  assign s1 = d1_valid ? r1.st : st;
  assign r2 = deliver(s1, d2_byte);
  assign e1 = d1_valid && r1.emit;
  assign e2 = d2_valid && r2.emit;

  // Status checks see the state after any trailing ENQ was delivered.
  always_comb begin
    s2                = d2_valid ? r2.st : s1;
    s2.escape_pending = esc_next;
    hv                = s1.header_seen && s1.held_valid;
    status            = '0;
    status.kind        = KIND_STATUS;
    status.checksum_ok = hv && (s1.held_value == 8'(8'd0 - s1.running_sum));
    status.length_ok   = hv && (s1.message_count == {1'b0, s1.length_value});
    status.nak_reply   = hv && (s1.length_value == NAK_LEN) &&
                         (s1.message_count == 9'd1) &&
                         (s1.first_message == SYM_NAK) &&
                         (s1.held_value == NAK_SUM);
  end

  always_comb begin
    it0     = e1 ? msg_item(r1.value) : (e2 ? msg_item(r2.value) : status);
    it1     = (e1 && e2) ? msg_item(r2.value) : status;
    n_items = 2'(e1) + 2'(e2) + 2'(close_frame);
  end

  always_comb begin
    st_next = st;
    if (rx_xfer) begin
      if (open_frame) begin
        st_next             = IDLE_STATE;
        st_next.in_frame    = 1'b1;
        st_next.running_sum = SYM_STX;
      end else if (close_frame) begin
        st_next = IDLE_STATE;
      end else begin
        st_next = s2;
      end
    end
  end

  assign count_next = count + (rx_xfer ? 3'(n_items) : 3'd0) - 3'(res_xfer);

  always_ff @(posedge clk) begin
    if (rst) begin
      st     <= IDLE_STATE;
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      st    <= st_next;
      count <= count_next;
      if (rx_xfer) begin
        wr_ptr <= wr_ptr + n_items;
      end
      if (res_xfer) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
    end
  end

  // queue payload, no reset needed
  always_ff @(posedge clk) begin
    if (rx_xfer && (n_items != '0)) begin
      fifo[wr_ptr] <= it0;
      if (n_items == 2'd2) begin
        fifo[wr_ptr + 2'd1] <= it1;
      end
    end
  end

  assign item_kind   = fifo[rd_ptr].kind;
  assign msg_byte    = fifo[rd_ptr].value;
  assign checksum_ok = fifo[rd_ptr].checksum_ok;
  assign length_ok   = fifo[rd_ptr].length_ok;
  assign nak_reply   = fifo[rd_ptr].nak_reply;
  assign frame_last  = fifo[rd_ptr].kind;

  `EFR_ASSERT_NOW(a_queue_bound, 1'b1, count <= 3'd4, "result queue overflow")
  `EFR_ASSERT_NEXT(a_stx_opens, rx_xfer && (rx_byte == SYM_STX), st.in_frame,
    "STX did not open a frame")
  `EFR_ASSERT_NEXT(a_etx_closes, rx_xfer && st.in_frame && (rx_byte == SYM_ETX),
    !st.in_frame && !st.escape_pending && res_valid, "ETX did not close the frame")
  `EFR_ASSERT_NOW(a_idle_clean, !st.in_frame,
    !st.escape_pending && !st.held_valid && !st.header_seen,
    "frame state left outside a frame")

endmodule
